/* rtl/csp_pkg.sv */
// Shared types and constants for the color string parser.
package csp_pkg;

  typedef struct packed {
    logic [7:0] char_code;
    logic       char_present;
    logic       last_char;
  } in_word_t;

  typedef struct packed {
    logic       parse_ok;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic       alpha_given;
  } out_word_t;

  typedef struct packed {
    logic [1:0]      form_mode;
    logic [3:0]      char_count;
    logic            reject_flag;
    logic [31:0]     nibble_store;
    logic [2:0]      field_phase;
    logic [3:0][7:0] comp_values;
    logic [3:0]      comp_seen;
  } state_t;

  localparam logic [1:0] MODE_UNDECIDED = 2'd0;
  localparam logic [1:0] MODE_HEX       = 2'd1;
  localparam logic [1:0] MODE_DEC       = 2'd2;

  localparam logic [3:0] COUNT_MAX = 4'd10;

  // decimal field phases
  localparam logic [2:0] PH_RED   = 3'd0;
  localparam logic [2:0] PH_ALPHA = 3'd6;

  localparam logic [7:0] CHAR_HASH  = 8'h23;
  localparam logic [7:0] CHAR_COMMA = 8'h2c;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_0     = 8'h30;
  localparam logic [7:0] CHAR_9     = 8'h39;
  localparam logic [7:0] CHAR_UA    = 8'h41;
  localparam logic [7:0] CHAR_UF    = 8'h46;
  localparam logic [7:0] CHAR_LA    = 8'h61;
  localparam logic [7:0] CHAR_LF    = 8'h66;

  localparam logic [7:0] BYTE_FULL = 8'hff;

  localparam state_t STATE_INIT = '0;

endpackage

/* rtl/csp_step.sv */
// Per-character state update and result formatting for the color string parser.
module csp_step (
  input  csp_pkg::state_t    st,
  input  csp_pkg::in_word_t  word,
  output csp_pkg::state_t    st_next,
  output csp_pkg::out_word_t result
);
  import csp_pkg::*;

  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [7:0] d;
    begin
      d = '0;
      if (c >= CHAR_0 && c <= CHAR_9) begin
        d = c - CHAR_0;
        hex_value = {1'b1, d[3:0]};
      end else if (c >= CHAR_UA && c <= CHAR_UF) begin
        d = c - CHAR_UA + 8'd10;
        hex_value = {1'b1, d[3:0]};
      end else if (c >= CHAR_LA && c <= CHAR_LF) begin
        d = c - CHAR_LA + 8'd10;
        hex_value = {1'b1, d[3:0]};
      end else begin
        hex_value = '0;
      end
    end
  endfunction

  logic [7:0]  c;
  logic [4:0]  hv;
  logic        digit_char;
  logic        delim_char;
  logic [2:0]  ph;
  logic [1:0]  idx;
  logic [7:0]  digit_val;
  logic [11:0] acc;
  logic [3:0]  digits;
  logic [31:0] s;

  assign c          = word.char_code;
  assign hv         = hex_value(c);
  assign digit_char = (c >= CHAR_0) && (c <= CHAR_9);
  assign delim_char = (c == CHAR_SPACE) || (c == CHAR_COMMA);
  assign digit_val  = c - CHAR_0;

  always_comb begin
    st_next = st;
    ph      = st.field_phase + {2'b0, st.field_phase[0]};
    idx     = ph[2:1];
    acc     = {4'b0, st.comp_values[idx]} * 12'd10 + {8'b0, digit_val[3:0]};
    if (word.char_present) begin
      if (st.char_count < COUNT_MAX) st_next.char_count = st.char_count + 4'd1;
      if (st.form_mode == MODE_UNDECIDED && c == CHAR_HASH) begin
        st_next.form_mode = MODE_HEX;
      end else if (st.form_mode == MODE_HEX) begin
        if (!hv[4]) st_next.reject_flag = 1'b1;
        else st_next.nibble_store = {st.nibble_store[27:0], hv[3:0]};
      end else begin
        st_next.form_mode = MODE_DEC;
        if (st.field_phase > PH_ALPHA || !(digit_char || delim_char)) begin
          st_next.reject_flag = 1'b1;
        end else if (digit_char) begin
          st_next.field_phase      = ph;
          st_next.comp_seen[idx]   = 1'b1;
          st_next.comp_values[idx] = acc[7:0];
          if (acc > 12'd255) st_next.reject_flag = 1'b1;
        end else if (!st.field_phase[0]) begin
          if (st.field_phase == PH_ALPHA) st_next.reject_flag = 1'b1;
          else st_next.field_phase = st.field_phase + 3'd1;
        end
      end
    end
  end

  // digit count excludes the leading '#'
  assign digits = st_next.char_count - 4'd1;
  assign s      = st_next.nibble_store;

  always_comb begin
    result = '0;
    if (!st_next.reject_flag && st_next.form_mode == MODE_HEX) begin
      case (digits)
        4'd3: begin
          result = '{1'b1, {2{s[11:8]}}, {2{s[7:4]}}, {2{s[3:0]}}, BYTE_FULL, 1'b0};
        end
        4'd4: begin
          result = '{1'b1, {2{s[15:12]}}, {2{s[11:8]}}, {2{s[7:4]}}, {2{s[3:0]}}, 1'b1};
        end
        4'd6: begin
          result = '{1'b1, s[23:16], s[15:8], s[7:0], BYTE_FULL, 1'b0};
        end
        4'd8: begin
          result = '{1'b1, s[31:24], s[23:16], s[15:8], s[7:0], 1'b1};
        end
        default: result = '0;
      endcase
    end else if (!st_next.reject_flag && st_next.form_mode == MODE_DEC &&
                 st_next.comp_seen[0] && st_next.comp_seen[1] && st_next.comp_seen[2]) begin
      result.parse_ok    = 1'b1;
      result.red         = st_next.comp_values[0];
      result.green       = st_next.comp_values[1];
      result.blue        = st_next.comp_values[2];
      result.alpha_given = st_next.comp_seen[3];
      result.alpha       = st_next.comp_seen[3] ? st_next.comp_values[3] : BYTE_FULL;
    end
  end

endmodule

/* rtl/color_string_parser_unit.sv */
// Top level of the color string parser: input register, state, result register.
//
//   channel | valid        | ready        | word
//   --------+--------------+--------------+-------------------------------
//   input   | char_valid   | char_ready   | char_word   (csp_pkg::in_word_t)
//   result  | result_valid | result_ready | result_word (csp_pkg::out_word_t)
//
// One character word per cycle, unless a stalled result holds a last_char word; a result
// is loaded into the result register when the last_char word moves out of the input register.
// The parse state update is combinational and sets the rate: one word per cycle.
// Reset (rst, synchronous) empties both registers and clears the parse state.
// A stalled result holds only a last_char word in the input register; other words
// keep flowing.
module color_string_parser_unit (
  input  logic                clk,
  input  logic                rst,
  input  logic                char_valid,
  output logic                char_ready,
  input  csp_pkg::in_word_t   char_word,
  output logic                result_valid,
  input  logic                result_ready,
  output csp_pkg::out_word_t  result_word
);
  import csp_pkg::*;

  logic      hold_valid;
  in_word_t  hold_word;
  state_t    st;
  state_t    st_next;
  out_word_t step_result;
  logic      hold_move;

  csp_step u_step (
    .st      (st),
    .word    (hold_word),
    .st_next (st_next),
    .result  (step_result)
  );

  assign hold_move  = hold_valid && (!hold_word.last_char || !result_valid || result_ready);
  assign char_ready = !hold_valid || hold_move;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (char_ready) begin
      hold_valid <= char_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (char_ready && char_valid) hold_word <= char_word;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= STATE_INIT;
    end else if (hold_move) begin
      st <= hold_word.last_char ? STATE_INIT : st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (hold_move && hold_word.last_char) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (hold_move && hold_word.last_char) result_word <= step_result;
  end

endmodule

/* tb/color_string_parser_unit_test.sv */
// Self-checking testbench for the color string parser: directed strings, then random ones.
module color_string_parser_unit_test;
  import csp_pkg::*;

  localparam int RANDOM_WORDS = 350;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 8;

  logic      clk;
  logic      rst          = 1'b1;
  logic      char_valid   = 1'b0;
  logic      char_ready;
  in_word_t  char_word    = '0;
  logic      result_valid;
  logic      result_ready = 1'b0;
  out_word_t result_word;

  state_t    parse_st = STATE_INIT;
  out_word_t expected_colors[$];
  int        mismatches = 0;
  int        words_sent = 0;
  int        cycles     = 0;
  bit        src_idle_on  = 1'b1;
  bit        sink_idle_on = 1'b1;

  color_string_parser_unit dut (
    .clk          (clk),
    .rst          (rst),
    .char_valid   (char_valid),
    .char_ready   (char_ready),
    .char_word    (char_word),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result_word  (result_word)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d results still expected", $time, expected_colors.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------- predictor

  function automatic int hex_nibble(logic [7:0] c);
    if (c >= CHAR_0 && c <= CHAR_9) return int'(c - CHAR_0);
    if (c >= CHAR_UA && c <= CHAR_UF) return int'(c - CHAR_UA) + 10;
    if (c >= CHAR_LA && c <= CHAR_LF) return int'(c - CHAR_LA) + 10;
    return -1;
  endfunction

  function automatic void take_decimal_char(logic [7:0] c);
    bit        digit;
    bit        delim;
    logic [1:0] idx;
    int        acc;
    digit = (c >= CHAR_0 && c <= CHAR_9);
    delim = (c == CHAR_SPACE || c == CHAR_COMMA);
    if (parse_st.field_phase > PH_ALPHA || !(digit || delim)) begin
      parse_st.reject_flag = 1'b1;
    end else if (digit) begin
      // first digit after a delimiter run opens the next component
      if (parse_st.field_phase[0]) parse_st.field_phase = parse_st.field_phase + 3'd1;
      idx = parse_st.field_phase[2:1];
      acc = int'(parse_st.comp_values[idx]) * 10 + int'(c - CHAR_0);
      parse_st.comp_seen[idx] = 1'b1;
      if (acc > 255) parse_st.reject_flag = 1'b1;
      parse_st.comp_values[idx] = acc[7:0];
    end else if (!parse_st.field_phase[0]) begin
      if (parse_st.field_phase == PH_ALPHA) parse_st.reject_flag = 1'b1;
      else parse_st.field_phase = parse_st.field_phase + 3'd1;
    end
  endfunction

  function automatic out_word_t finish_color();
    out_word_t  res;
    logic [31:0] s;
    int         digits;
    res = '0;
    s = parse_st.nibble_store;
    digits = int'(parse_st.char_count) - 1;
    if (!parse_st.reject_flag && parse_st.form_mode == MODE_HEX) begin
      res.parse_ok = 1'b1;
      case (digits)
        3: begin
          res.red   = {s[11:8], s[11:8]};
          res.green = {s[7:4], s[7:4]};
          res.blue  = {s[3:0], s[3:0]};
          res.alpha = BYTE_FULL;
        end
        4: begin
          res.red   = {s[15:12], s[15:12]};
          res.green = {s[11:8], s[11:8]};
          res.blue  = {s[7:4], s[7:4]};
          res.alpha = {s[3:0], s[3:0]};
          res.alpha_given = 1'b1;
        end
        6: begin
          res.red   = s[23:16];
          res.green = s[15:8];
          res.blue  = s[7:0];
          res.alpha = BYTE_FULL;
        end
        8: begin
          res.red   = s[31:24];
          res.green = s[23:16];
          res.blue  = s[15:8];
          res.alpha = s[7:0];
          res.alpha_given = 1'b1;
        end
        default: res = '0;
      endcase
    end else if (!parse_st.reject_flag && parse_st.form_mode == MODE_DEC &&
                 (&parse_st.comp_seen[2:0])) begin
      res.parse_ok    = 1'b1;
      res.red         = parse_st.comp_values[0];
      res.green       = parse_st.comp_values[1];
      res.blue        = parse_st.comp_values[2];
      res.alpha_given = parse_st.comp_seen[3];
      res.alpha       = parse_st.comp_seen[3] ? parse_st.comp_values[3] : BYTE_FULL;
    end
    return res;
  endfunction

  function automatic void predict_word(in_word_t w);
    int v;
    bit body;
    body = w.char_present;
    if (w.char_present) begin
      if (parse_st.char_count < COUNT_MAX) parse_st.char_count = parse_st.char_count + 4'd1;
      if (parse_st.form_mode == MODE_UNDECIDED) begin
        parse_st.form_mode = (w.char_code == CHAR_HASH) ? MODE_HEX : MODE_DEC;
        if (w.char_code == CHAR_HASH) body = 1'b0;  // '#' only picks hex form
      end
      if (body) begin
        if (parse_st.form_mode == MODE_HEX) begin
          v = hex_nibble(w.char_code);
          if (v < 0) parse_st.reject_flag = 1'b1;
          else parse_st.nibble_store = {parse_st.nibble_store[27:0], v[3:0]};
        end else begin
          take_decimal_char(w.char_code);
        end
      end
    end
    if (w.last_char) begin
      expected_colors.push_back(finish_color());
      parse_st = STATE_INIT;
    end
  endfunction

  // ---------------------------------------------------------------- driving

  task automatic send_char(input logic [7:0] code, input logic present, input logic last);
    in_word_t w;
    int       gap;
    w.char_code    = code;
    w.char_present = present;
    w.last_char    = last;
    gap = src_idle_on ? $urandom_range(0, 15) : 0;
    if (gap > 0) begin
      char_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    char_valid <= 1'b1;
    char_word  <= w;
    @(posedge clk);
    while (!char_ready) @(posedge clk);
    predict_word(w);
    words_sent++;
  endtask

  // blank_end: close the string with an empty word instead of flagging the last character
  task automatic send_text(ref logic [7:0] txt[$], input bit blank_end, input bit blanks_inside);
    for (int i = 0; i < txt.size(); i++) begin
      if (blanks_inside && $urandom_range(0, 7) == 0)
        send_char(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      send_char(txt[i], 1'b1, (i == txt.size() - 1) && !blank_end);
    end
    if (blank_end || txt.size() == 0) send_char(8'($urandom_range(0, 255)), 1'b0, 1'b1);
  endtask

  task automatic send_string(input string s, input bit blank_end = 1'b0);
    logic [7:0] txt[$];
    for (int i = 0; i < s.len(); i++) txt.push_back(s[i]);
    send_text(txt, blank_end, 1'b0);
  endtask

  // result side: random stall before each word, then wait for it
  initial begin
    int stall;
    forever begin
      stall = sink_idle_on ? $urandom_range(0, 15) : 0;
      if (stall > 0) begin
        result_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      result_ready <= 1'b1;
      @(posedge clk);
      while (!(result_valid && !rst)) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    out_word_t want;
    if (!rst && result_valid && result_ready) begin
      if (expected_colors.size() == 0) begin
        $display("%0t: unexpected result word %p", $time, result_word);
        mismatches++;
      end else begin
        want = expected_colors.pop_front();
        if (result_word.parse_ok !== want.parse_ok) begin
          $display("%0t: parse_ok exp %0b got %0b", $time, want.parse_ok, result_word.parse_ok);
          mismatches++;
        end
        if (result_word.red !== want.red) begin
          $display("%0t: red exp %02h got %02h", $time, want.red, result_word.red);
          mismatches++;
        end
        if (result_word.green !== want.green) begin
          $display("%0t: green exp %02h got %02h", $time, want.green, result_word.green);
          mismatches++;
        end
        if (result_word.blue !== want.blue) begin
          $display("%0t: blue exp %02h got %02h", $time, want.blue, result_word.blue);
          mismatches++;
        end
        if (result_word.alpha !== want.alpha) begin
          $display("%0t: alpha exp %02h got %02h", $time, want.alpha, result_word.alpha);
          mismatches++;
        end
        if (result_word.alpha_given !== want.alpha_given) begin
          $display("%0t: alpha_given exp %0b got %0b", $time, want.alpha_given,
                   result_word.alpha_given);
          mismatches++;
        end
      end
    end
  end

  // ---------------------------------------------------------------- string builders

  function automatic logic [7:0] rand_hex_char();
    int v;
    v = $urandom_range(0, 15);
    if (v < 10) return CHAR_0 + 8'(v);
    return ($urandom_range(0, 1) ? CHAR_UA : CHAR_LA) + 8'(v - 10);
  endfunction

  function automatic void build_hex(ref logic [7:0] txt[$], input int n_digits);
    txt.push_back(CHAR_HASH);
    repeat (n_digits) txt.push_back(rand_hex_char());
  endfunction

  function automatic void build_decimal(ref logic [7:0] txt[$], input int max_val,
                                        input int n_comp, input bit trail);
    string num;
    int    v;
    for (int k = 0; k < n_comp; k++) begin
      if (k > 0 || trail && k == n_comp)
        repeat ($urandom_range(1, 3)) txt.push_back($urandom_range(0, 1) ? CHAR_SPACE : CHAR_COMMA);
      case ($urandom_range(0, 5))
        0: v = 0;
        1: v = 255;
        default: v = $urandom_range(0, max_val);
      endcase
      num = $sformatf("%0d", v);
      for (int i = 0; i < num.len(); i++) txt.push_back(num[i]);
    end
    if (trail) repeat ($urandom_range(1, 3))
      txt.push_back($urandom_range(0, 1) ? CHAR_SPACE : CHAR_COMMA);
  endfunction

  // ---------------------------------------------------------------- tests

  task automatic test_hex_forms();
    send_string("#abc");
    send_string("#F0e8");
    send_string("#00ff7F");
    send_string("#FFFFFFFF", 1'b1);
    send_string("#00000000");
    send_string("#12345");       // wrong length
    send_string("#");
    send_string("#12#");         // second hash
    send_string("#1234567890");  // count saturates
    send_string("#12g");
  endtask

  task automatic test_decimal_forms();
    send_string("255,0 ,255");
    send_string("0 0 0 0");
    send_string("1,2,3,,  ");    // trailing delimiters after blue
    send_string("12,34,56,78");
    send_string("256,0,0");      // overflow
    send_string("1,2");          // blue missing
    send_string(",1,2,3");       // red missing
    send_string("1,,2,x");
    send_string("1,2,3,4 ");     // delimiter after alpha
    send_string("9,8,7,255", 1'b1);
  endtask

  task automatic test_odd_words();
    logic [7:0] txt[$];
    send_char(8'h00, 1'b0, 1'b1);  // empty string
    send_char(8'hff, 1'b0, 1'b0);
    send_char(CHAR_HASH, 1'b1, 1'b0);
    send_char(8'h00, 1'b0, 1'b0);
    send_char(CHAR_LA, 1'b1, 1'b0);
    send_char(CHAR_UF, 1'b1, 1'b0);
    send_char(CHAR_9, 1'b1, 1'b1);
    txt = {8'h00, CHAR_COMMA};
    send_text(txt, 1'b0, 1'b0);
    txt = {CHAR_HASH, 8'hff};
    send_text(txt, 1'b0, 1'b0);
  endtask

  task automatic test_random_strings();
    logic [7:0] txt[$];
    string      alphabet;
    int         stop_at;
    int         pos;
    alphabet = "0123456789 ,#aFgz";
    stop_at = words_sent + RANDOM_WORDS;
    while (words_sent < stop_at) begin
      src_idle_on  = ($urandom_range(0, 3) != 0);
      sink_idle_on = ($urandom_range(0, 3) != 0);
      txt.delete();
      case ($urandom_range(0, 15))
        0, 1, 2, 3, 4: begin
          case ($urandom_range(0, 3))
            0: build_hex(txt, 3);
            1: build_hex(txt, 4);
            2: build_hex(txt, 6);
            default: build_hex(txt, 8);
          endcase
        end
        5, 6, 7, 8, 9: begin
          if ($urandom_range(0, 1)) build_decimal(txt, 255, 3, 1'($urandom_range(0, 1)));
          else build_decimal(txt, 255, 4, 1'b0);
        end
        10, 11: begin
          if ($urandom_range(0, 1)) build_hex(txt, 6);
          else build_decimal(txt, 255, 3, 1'b0);
          pos = $urandom_range(0, txt.size() - 1);
          case ($urandom_range(0, 2))
            0: txt[pos] = 8'($urandom_range(0, 255));
            1: txt.delete(pos);
            default: txt.insert(pos, txt[pos]);
          endcase
        end
        12: build_hex(txt, $urandom_range(0, 10));
        13: build_decimal(txt, 999, $urandom_range(1, 5), 1'($urandom_range(0, 1)));
        14: repeat ($urandom_range(0, 12)) txt.push_back(8'($urandom_range(0, 255)));
        default: repeat ($urandom_range(1, 12))
          txt.push_back(alphabet[$urandom_range(0, alphabet.len() - 1)]);
      endcase
      send_text(txt, $urandom_range(0, 3) == 0, $urandom_range(0, 3) == 0);
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_hex_forms();
    test_decimal_forms();
    test_odd_words();
    test_random_strings();
    char_valid <= 1'b0;
    while (expected_colors.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_colors.size() == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
